/* rtl/sha_pkg.sv */
// Shared types, constants and tables of the streaming SHA-256 hasher.
`default_nettype none

package sha_pkg;

  typedef logic [31:0] word_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_OUT
  } sha_state_e;

  // Control bundle from the sequencer to the compression datapath.
  typedef struct packed {
    logic       shift_en;
    logic [7:0] shift_byte;
    logic       load_vars;
    logic       round_en;
    logic [5:0] round_idx;
    logic       add_hash;
    logic       init_hash;
  } sha_ctl_t;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_IDX   = 3'd7;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  // Initial hash value.
  localparam word_t HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants.
  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

/* rtl/sha_core.sv */
// Compression datapath: block shift window, one shared round unit and the chaining value.
`default_nettype none

module sha_core import sha_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sha_ctl_t ctl_i,
  output word_t    hash_o [8]
);

  word_t win_q  [16];
  word_t win_d  [16];
  word_t var_q  [8];
  word_t var_d  [8];
  word_t hash_q [8];
  word_t hash_d [8];

  word_t w_sched;
  word_t w_t;
  word_t t1;
  word_t t2;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sml_sig0(input word_t x);
    sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sml_sig1(input word_t x);
    sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_sig0(input word_t x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  // Schedule word: the first sixteen rounds take the block words as they
  // rotate through the window, later rounds extend the schedule.
  always_comb begin
    w_sched = sml_sig1(win_q[14]) + win_q[9] + sml_sig0(win_q[1]) + win_q[0];
    w_t     = (ctl_i.round_idx[5:4] == 2'b00) ? win_q[0] : w_sched;
  end

  // Round function on the working variables a..h.
  always_comb begin
    t1 = var_q[7] + big_sig1(var_q[4]) +
         ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6])) +
         ROUND_K[ctl_i.round_idx] + w_t;
    t2 = big_sig0(var_q[0]) +
         ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));
  end

  // Window: bytes shift in at the bottom, rounds rotate word by word.
  always_comb begin
    win_d = win_q;
    if (ctl_i.shift_en) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_d[15] = {win_q[15][23:0], ctl_i.shift_byte};
    end else if (ctl_i.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[15] = w_t;
    end
  end

  // Working variables load from the chaining value, then step once a round.
  always_comb begin
    var_d = var_q;
    if (ctl_i.load_vars) begin
      var_d = hash_q;
    end else if (ctl_i.round_en) begin
      var_d[7] = var_q[6];
      var_d[6] = var_q[5];
      var_d[5] = var_q[4];
      var_d[4] = var_q[3] + t1;
      var_d[3] = var_q[2];
      var_d[2] = var_q[1];
      var_d[1] = var_q[0];
      var_d[0] = t1 + t2;
    end
  end

  // Chaining value: feed-forward after a block, back to the initial value per message.
  always_comb begin
    hash_d = hash_q;
    if (ctl_i.init_hash) begin
      hash_d = HASH_IV;
    end else if (ctl_i.add_hash) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + var_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    var_q <= var_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HASH_IV;
    end else begin
      hash_q <= hash_d;
    end
  end

  assign hash_o = hash_q;

endmodule

`default_nettype wire

/* rtl/sha256_stream_hasher.sv */
// Top level: byte intake, padding sequencer, round counter and digest output.
// A byte that neither fills a block nor ends the message leaves the input ready. A byte
// that fills a block holds the input while the 64 rounds run on the shared round unit and
// the feed-forward follows. End of message pads byte by byte (up to 64 pad bytes, or 72 when
// the length spills into a second block) and compresses each padded block with 64 rounds and
// a feed-forward, then eight digest items go out, one per cycle when out_ready_i is high.
// Reset loads the initial hash value and clears counters; the byte window needs no clearing.
`default_nettype none

module sha256_stream_hasher import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha_state_e  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic [63:0] bit_cnt_q, bit_cnt_d;
  logic        fin_q, fin_d;
  logic        first_q, first_d;
  logic        len_ok_q, len_ok_d;
  logic        last_q, last_d;

  logic        in_fire;
  logic        out_fire;
  logic [63:0] len_sh;
  sha_ctl_t    ctl;
  word_t       hash [8];

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;

  // Length bytes go out most significant first at block positions 56 to 63.
  assign len_sh = bit_cnt_q << {fill_q[2:0], 3'b000};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (byte_present_i && (fill_q == LAST_POS)) begin
            state_d = ST_ROUND;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (rnd_q == LAST_ROUND) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (last_q) begin
          state_d = ST_OUT;
        end else if (fin_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (fill_q == LAST_POS) begin
          state_d = ST_ROUND;
        end
      end
      ST_OUT: begin
        if (out_fire && (idx_q == LAST_IDX)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs and counter updates.
  always_comb begin
    fill_d      = fill_q;
    rnd_d       = rnd_q;
    idx_d       = idx_q;
    bit_cnt_d   = bit_cnt_q;
    fin_d       = fin_q;
    first_d     = first_q;
    len_ok_d    = len_ok_q;
    last_d      = last_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctl         = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire) begin
          fin_d   = end_of_message_i;
          first_d = end_of_message_i;
          if (byte_present_i) begin
            ctl.shift_en   = 1'b1;
            ctl.shift_byte = data_byte_i;
            fill_d         = fill_q + 6'd1;
            bit_cnt_d      = bit_cnt_q + BYTE_BITS;
            if (fill_q == LAST_POS) begin
              ctl.load_vars = 1'b1;
              rnd_d         = '0;
              last_d        = 1'b0;
            end
          end
        end
      end
      ST_ROUND: begin
        ctl.round_en  = 1'b1;
        ctl.round_idx = rnd_q;
        rnd_d         = rnd_q + 6'd1;
      end
      ST_UPDATE: begin
        ctl.add_hash = 1'b1;
        len_ok_d     = 1'b1;
      end
      ST_PAD: begin
        ctl.shift_en = 1'b1;
        if (first_q) begin
          ctl.shift_byte = PAD_BYTE;
          len_ok_d       = (fill_q < LEN_POS);
        end else if (len_ok_q && (fill_q >= LEN_POS)) begin
          ctl.shift_byte = len_sh[63:56];
        end else begin
          ctl.shift_byte = 8'h00;
        end
        first_d = 1'b0;
        fill_d  = fill_q + 6'd1;
        if (fill_q == LAST_POS) begin
          ctl.load_vars = 1'b1;
          rnd_d         = '0;
          last_d        = !first_q && len_ok_q;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_fire) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LAST_IDX) begin
            ctl.init_hash = 1'b1;
            bit_cnt_d     = '0;
            fill_d        = '0;
            fin_d         = 1'b0;
            last_d        = 1'b0;
          end
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      rnd_q     <= '0;
      idx_q     <= '0;
      bit_cnt_q <= '0;
      fin_q     <= 1'b0;
      first_q   <= 1'b0;
      len_ok_q  <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      rnd_q     <= rnd_d;
      idx_q     <= idx_d;
      bit_cnt_q <= bit_cnt_d;
      fin_q     <= fin_d;
      first_q   <= first_d;
      len_ok_q  <= len_ok_d;
      last_q    <= last_d;
    end
  end

  sha_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .hash_o (hash)
  );

  // Digest item output straight from the chaining value.
  assign digest_word_o = hash[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == LAST_IDX);

`ifndef SYNTHESIS
  // Input and output sides are never open in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted while digest is pending");

  // Every compression starts at round zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_ROUND) |-> (rnd_q == '0))
    else $error("compression started at a nonzero round");

  // The final block always leaves the byte counter block-aligned and digest output at word 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && last_q) |=> (state_q == ST_OUT && idx_q == '0 && fill_q == '0))
    else $error("digest output entered with bad alignment");

  // After the last digest word the message state is back to its start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_word_o) |=> (state_q == ST_IDLE && bit_cnt_q == '0 && !fin_q))
    else $error("message state not cleared after digest");
`endif

endmodule

`default_nettype wire
